// ===== hdl/aob_pkg.sv =====
// Package: types, widening tables and packing helper for the ARGB-over-RGB565 blender
`timescale 1ns / 1ps
package aob_pkg;

  typedef logic [7:0] lut32_t [32];
  typedef logic [7:0] lut64_t [64];

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb888_t;

  function automatic lut32_t build_widen5();
    lut32_t tbl;
    for (int i = 0; i < 32; i++) begin
      tbl[i] = 8'((i * 255) / 31);
    end
    return tbl;
  endfunction

  function automatic lut64_t build_widen6();
    lut64_t tbl;
    for (int i = 0; i < 64; i++) begin
      tbl[i] = 8'((i * 255) / 63);
    end
    return tbl;
  endfunction

  localparam lut32_t Widen5Lut = build_widen5();
  localparam lut64_t Widen6Lut = build_widen6();

  localparam logic [7:0] AlphaClear  = 8'h00;
  localparam logic [7:0] AlphaOpaque = 8'hFF;

  function automatic logic [15:0] pack565(rgb888_t c);
    return {c.r[7:3], c.g[7:2], c.b[7:3]};
  endfunction

endpackage

// ===== hdl/aob_bg_reg.sv =====
// Background color register with its 8-bit-per-channel widened copy
`timescale 1ns / 1ps
module aob_bg_reg
  import aob_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic [15:0] bg_raw_o,
  output rgb888_t     bg_wide_o
);

  logic [15:0] bg_q;
  rgb888_t     wide_q;
  rgb888_t     wide_d;

  always_comb begin
    wide_d.r = Widen5Lut[cfg_wdata_i[15:11]];
    wide_d.g = Widen6Lut[cfg_wdata_i[10:5]];
    wide_d.b = Widen5Lut[cfg_wdata_i[4:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q   <= '0;
      wide_q <= '0;
    end else if (cfg_we_i) begin
      bg_q   <= cfg_wdata_i;
      wide_q <= wide_d;
    end
  end

  assign bg_raw_o  = bg_q;
  assign bg_wide_o = wide_q;

endmodule

// ===== hdl/aob_mix.sv =====
// One channel of the alpha mix: (src*a + bg*(255-a)) / 255, truncated
`timescale 1ns / 1ps
module aob_mix
  import aob_pkg::*;
(
  input  logic [7:0] src_i,
  input  logic [7:0] bg_i,
  input  logic [7:0] alpha_i,
  output logic [7:0] mix_o
);

  logic signed [8:0]  diff;
  logic signed [17:0] prod;
  logic        [16:0] base;
  logic signed [17:0] sum;
  logic        [15:0] num;
  logic        [16:0] quot;

  // bg*255 + (src - bg)*a, then divide by 255 via x + (x >> 8) + 1 >> 8
  always_comb begin
    diff = $signed({1'b0, src_i}) - $signed({1'b0, bg_i});
    prod = $signed({{9{diff[8]}}, diff}) * $signed({10'b0, alpha_i});
    base = {1'b0, bg_i, 8'b0} - {9'b0, bg_i};
    sum  = prod + $signed({1'b0, base});
    num  = sum[15:0];
    quot = {1'b0, num} + {9'b0, num[15:8]} + 17'd1;
  end

  assign mix_o = quot[15:8];

endmodule

// ===== hdl/argb_over_rgb565_blend.sv =====
// Top level: ARGB8888 pixel blended over an RGB565 background color
// Pipeline: input reg, then result reg; a word moves on when the result reg is empty or the output is not stalled.
// Throughput: one pixel per cycle while the output is not stalled; the mix is one 9x9 multiply per channel.
// Stall from the output propagates back through both registers in the same cycle.
// Reset: both pipeline stages empty, background color and its widened copy cleared to 0.
`timescale 1ns / 1ps
module argb_over_rgb565_blend
  import aob_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] pixel_argb_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_rgb565_o
);

  logic        in_valid_q;
  logic [31:0] pix_q;
  logic        res_valid_q;
  logic [15:0] res_q;
  logic [15:0] res_d;
  logic        adv_res;
  logic        adv_in;
  logic [15:0] bg_raw;
  rgb888_t     bg_wide;
  rgb888_t     src;
  rgb888_t     mixed;
  logic [7:0]  alpha;

  aob_bg_reg u_bg_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .bg_raw_o    (bg_raw),
    .bg_wide_o   (bg_wide)
  );

  assign alpha = pix_q[31:24];
  assign src   = pix_q[23:0];

  aob_mix u_mix_r (.src_i(src.r), .bg_i(bg_wide.r), .alpha_i(alpha), .mix_o(mixed.r));
  aob_mix u_mix_g (.src_i(src.g), .bg_i(bg_wide.g), .alpha_i(alpha), .mix_o(mixed.g));
  aob_mix u_mix_b (.src_i(src.b), .bg_i(bg_wide.b), .alpha_i(alpha), .mix_o(mixed.b));

  always_comb begin
    if (alpha == AlphaClear) begin
      res_d = bg_raw;
    end else if (alpha == AlphaOpaque) begin
      res_d = pack565(src);
    end else begin
      res_d = pack565(mixed);
    end
  end

  assign adv_res    = !res_valid_q || !out_stall_i;
  assign adv_in     = !in_valid_q || adv_res;
  assign in_stall_o = !adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_valid_q <= in_valid_i;
      end
      if (adv_res) begin
        res_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      pix_q <= pixel_argb_i;
    end
    if (adv_res && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign pixel_rgb565_o = res_q;

  a_empty_stage_accepts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  a_input_word_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_stall_o) |=> (in_valid_q && $stable(pix_q)))
    else $error("input register lost a stalled word");

  a_result_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_stall_i) |=> out_valid_o)
    else $error("result register failed to take a word");

endmodule

// ===== test/tb.sv =====
// Testbench for the ARGB8888-over-RGB565 blender: directed and random pixels checked by a predictor
`timescale 1ns / 1ps
module tb;
  import aob_pkg::*;

  localparam int PipeLatency = 2;
  localparam int IdleLimit   = 1000;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [15:0] cfg_wdata_i  = 16'h0000;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [31:0] pixel_argb_i = 32'h0000_0000;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [15:0] pixel_rgb565_o;

  logic [15:0] bg_color = 16'h0000;
  logic [15:0] pending_rgb565_q[$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  int          stall_mode;
  int          stall_span;
  int          stall_period;
  int          stall_phase;

  argb_over_rgb565_blend DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_argb_i   (pixel_argb_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_rgb565_o (pixel_rgb565_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] mix_channel(int unsigned src, int unsigned bg, int unsigned a);
    int unsigned sum;
    sum = src * a + bg * (255 - a);
    return 8'(sum / 255);
  endfunction

  function automatic logic [15:0] blend_over_background(logic [15:0] bg, logic [31:0] px);
    int unsigned a;
    int unsigned wide_r;
    int unsigned wide_g;
    int unsigned wide_b;
    rgb888_t     src;
    rgb888_t     mixed;
    a   = px[31:24];
    src = px[23:0];
    if (a == 0) begin
      return bg;
    end else if (a == 255) begin
      return {src.r[7:3], src.g[7:2], src.b[7:3]};
    end
    wide_r  = (int'(bg[15:11]) * 255) / 31;
    wide_g  = (int'(bg[10:5]) * 255) / 63;
    wide_b  = (int'(bg[4:0]) * 255) / 31;
    mixed.r = mix_channel(src.r, wide_r, a);
    mixed.g = mix_channel(src.g, wide_g, a);
    mixed.b = mix_channel(src.b, wide_b, a);
    return {mixed.r[7:3], mixed.g[7:2], mixed.b[7:3]};
  endfunction

  function automatic logic [31:0] random_pixel();
    logic [7:0] a;
    case ($urandom_range(0, 7))
      0:       a = AlphaClear;
      1:       a = AlphaOpaque;
      2:       a = ($urandom_range(0, 1) != 0) ? 8'h01 : 8'hFE;
      default: a = 8'($urandom);
    endcase
    return {a, 24'($urandom)};
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] %s: got %04h, want %04h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pixel(input logic [31:0] px);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid_i   <= 1'b0;
        pixel_argb_i <= 32'($urandom);
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    pixel_argb_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    pending_rgb565_q.push_back(blend_over_background(bg_color, px));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_rgb565_q.size() != 0);
  endtask

  task automatic set_background(input logic [15:0] color);
    drain_results();
    repeat (PipeLatency + 1) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= color;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    bg_color = color;
  endtask

  task automatic test_directed();
    logic [31:0] px_list[$];
    px_list = '{32'h0000_0000, 32'h00FF_FFFF, 32'hFFFF_FFFF, 32'hFF00_0000,
                32'hFF07_0307, 32'hFFF8_FCF8, 32'h01FF_FFFF, 32'hFE00_0000,
                32'h80AA_5533};
    foreach (px_list[i]) send_pixel(px_list[i]);
    set_background(16'hFFFF);
    px_list = '{32'h0012_3456, 32'hFF00_0000, 32'h0100_0000, 32'hFE00_0000,
                32'h7F00_0000, 32'h80FF_FFFF, 32'hFFFF_FFFF, 32'h01FF_FFFF,
                32'hFE12_8001, 32'h4055_AA00};
    foreach (px_list[i]) send_pixel(px_list[i]);
  endtask

  task automatic test_background_extremes();
    logic [15:0] bg_list[4];
    bg_list = '{16'hF800, 16'h07E0, 16'h001F, 16'h0000};
    foreach (bg_list[i]) begin
      set_background(bg_list[i]);
      repeat (40) send_pixel(random_pixel());
    end
  endtask

  task automatic test_random_backgrounds();
    repeat (8) begin
      set_background(16'($urandom));
      repeat (110) send_pixel(random_pixel());
    end
  endtask

  task automatic test_drain_pause();
    set_background(16'($urandom));
    repeat (3) begin
      repeat (30) send_pixel(random_pixel());
      drain_results();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rgb565_q.size() == 0) begin
        report_mismatch("unexpected word", pixel_rgb565_o, 16'h0000);
      end else if (pixel_rgb565_o !== pending_rgb565_q[0]) begin
        report_mismatch("pixel_rgb565", pixel_rgb565_o, pending_rgb565_q.pop_front());
      end else begin
        void'(pending_rgb565_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always begin
    stall_mode   = $urandom_range(0, 3);
    stall_span   = $urandom_range(20, 200);
    stall_period = $urandom_range(2, 6);
    stall_phase  = 0;
    repeat (stall_span) begin
      @(negedge clk_i);
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 2) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (stall_phase == 0);
      endcase
      stall_phase = (stall_phase + 1) % stall_period;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_background_extremes();
    test_random_backgrounds();
    test_drain_pause();
    drain_results();
    repeat (PipeLatency + 6) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/aob_pkg.sv
hdl/aob_bg_reg.sv
hdl/aob_mix.sv
hdl/argb_over_rgb565_blend.sv
test/tb.sv
